### rtl/swept_flanger_delay_core_macros.svh
// ----------------------------------------------------------------------------
// Swept flanger delay core assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SWEPT_FLANGER_DELAY_CORE_MACROS_SVH
`define SWEPT_FLANGER_DELAY_CORE_MACROS_SVH

// Same-cycle implication
`define SFD_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication
`define SFD_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Swept flanger delay package
// Shared constants, register map and configuration type.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // Delay line
   localparam int LINE_DEPTH  = 2048;
   localparam int LINE_ADDR_W = $clog2(LINE_DEPTH);

   // Sample and field widths
   localparam int SAMPLE_BITS = 16;
   localparam int OFFSET_BITS = 17;
   localparam int MS_BITS     = 16;
   localparam int SPM_BITS    = 15;
   localparam int GAIN_BITS   = 16;
   localparam int STEP_BITS   = 32;
   localparam int COUNT_BITS  = 32;
   localparam int REQ_DATA_W  = ((SAMPLE_BITS + OFFSET_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

   // Fixed point
   localparam int MAX_MS_Q11  = 49152;
   localparam int FRAC_BITS   = 19;
   localparam int SWEEP_SHIFT = 21;
   localparam int GAIN_FRAC   = 15;

   // Shared multiplier: signed A by signed B
   localparam int INTERP_W = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int MUL_A_W  = (INTERP_W > STEP_BITS + 1) ? INTERP_W : STEP_BITS + 1;
   localparam int MUL_B_W  = (SAMPLE_BITS + 1 > GAIN_BITS + 1) ? SAMPLE_BITS + 1
                                                                : GAIN_BITS + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int WET_W    = PROD_W - FRAC_BITS - GAIN_FRAC;
   localparam int ACC_W    = 64;

   // Register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_START_OFFSET = 2'd0;
   localparam logic [1:0] REG_SWEEP_STEP   = 2'd1;
   localparam logic [1:0] REG_DEPTH_GAIN   = 2'd2;
   localparam logic [1:0] REG_SAMPLES_MS   = 2'd3;

   localparam logic [GAIN_BITS-1:0] DEPTH_GAIN_RESET = 16'd32768;
   localparam logic [SPM_BITS-1:0]  SPM_RESET        = 15'd12288;

   typedef struct packed {
      logic [MS_BITS-1:0]   sweep_start_ms;
      logic [STEP_BITS-1:0] sweep_step;
      logic [GAIN_BITS-1:0] depth_gain;
      logic [SPM_BITS-1:0]  samples_per_ms;
   } cfg_type;

endpackage

### rtl/swept_flanger_delay_core.sv
// ----------------------------------------------------------------------------
// Swept flanger delay core
// Interpolated ring delay line with swept or overridden delay, one shared
// multiplier stepped by a small sequencer.
//
//   Port group  Direction  Carries
//   req_*       in         one dry sample with its delay override
//   rsp_*       out        one wet-plus-dry sample per input item
//   csr_*       in/out     start offset, sweep step, depth, samples per ms
//
// An item passes through the accepting cycle in idle plus 11 sequencer steps;
// no new item is taken before the sequencer is back in idle. The shared
// multiplier is used five times and the delay line read twice. The result is
// loaded into an output register as the sequencer returns to idle, and waits
// there while new work proceeds.
// After reset the delay line is cleared, one entry a cycle, through all 2048
// entries; no item is accepted meanwhile, register writes are.
// A stalled result output holds the sequencer in its final step.
// ----------------------------------------------------------------------------
`include "swept_flanger_delay_core_macros.svh"

module swept_flanger_delay_core
   import sfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_in, override_ms, zero pad
   input  logic                  req_tuser,   // use_offset_input
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // sample_out
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_MUL_LO = 4'd2;
   localparam logic [3:0] ST_MUL_HI = 4'd3;
   localparam logic [3:0] ST_SUM    = 4'd4;
   localparam logic [3:0] ST_CLAMP  = 4'd5;
   localparam logic [3:0] ST_DELAY  = 4'd6;
   localparam logic [3:0] ST_ADDR   = 4'd7;
   localparam logic [3:0] ST_RDB    = 4'd8;
   localparam logic [3:0] ST_DIFF   = 4'd9;
   localparam logic [3:0] ST_INTERP = 4'd10;
   localparam logic [3:0] ST_WET    = 4'd11;
   localparam logic [3:0] ST_OUT    = 4'd12;

   localparam logic signed [PROD_W-1:0] ROUND_HALF =
      PROD_W'(1) << (FRAC_BITS + GAIN_FRAC - 1);
   localparam logic signed [WET_W:0] SAMPLE_MAX = (WET_W + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [WET_W:0] SAMPLE_MIN = -SAMPLE_MAX - (WET_W + 1)'(1);

   cfg_type cfg;

   logic [3:0]                    state_ff, state_in;
   logic [LINE_ADDR_W-1:0]        clr_ff, clr_in;
   logic [LINE_ADDR_W-1:0]        wp_ff, wp_in;
   logic [COUNT_BITS-1:0]         cnt_ff, cnt_in;
   logic signed [SAMPLE_BITS-1:0] dry_ff;
   logic                          use_ff;
   logic signed [OFFSET_BITS-1:0] offset_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [MS_BITS-1:0]            ms_ff, ms_in;
   logic [FRAC_BITS-1:0]          fd_ff;
   logic [LINE_ADDR_W-1:0]        ia_ff;
   logic signed [SAMPLE_BITS-1:0] a_ff;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_data_ff, rsp_data_in;

   logic                          in_fire;
   logic                          out_load;
   logic                          out_step;
   logic                          mul_en;
   logic signed [MUL_A_W-1:0]     mul_a;
   logic signed [MUL_B_W-1:0]     mul_b;
   logic                          ram_we;
   logic [LINE_ADDR_W-1:0]        ram_waddr;
   logic [SAMPLE_BITS-1:0]        ram_wdata;
   logic [LINE_ADDR_W-1:0]        ram_raddr;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic [LINE_ADDR_W-1:0]        back;
   logic [LINE_ADDR_W-1:0]        ia_calc;
   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [ACC_W-1:0]       sweep_shifted;
   logic signed [ACC_W-1:0]       sweep_ms;
   logic signed [PROD_W-1:0]      wet_round;
   logic signed [WET_W-1:0]       wet;
   logic signed [WET_W:0]         mix;

   sfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfd_line_ram u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign in_fire    = req_tvalid & req_tready;
   assign out_load   = ~rsp_valid_ff | rsp_tready;
   assign out_step   = (state_ff == ST_OUT) & out_load;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // Delay line write: zero sweep after reset, new sample on acceptance
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wp_ff;
      ram_wdata = req_tdata[SAMPLE_BITS-1:0];
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (in_fire) begin
         ram_we = 1'b1;
      end
   end

   // Read index from the integer part of the delay, wrapped to the line
   assign back      = prod_ff[FRAC_BITS+LINE_ADDR_W-1:FRAC_BITS];
   assign ia_calc   = wp_ff - back;
   assign ram_raddr = (state_ff == ST_ADDR) ? ia_calc : ia_ff - LINE_ADDR_W'(1);

   assign diff = (SAMPLE_BITS + 1)'($signed(ram_rdata)) - (SAMPLE_BITS + 1)'(a_ff);

   // Shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_MUL_LO: begin
            mul_a = MUL_A_W'($signed(cfg.sweep_step));
            mul_b = $signed(MUL_B_W'(cnt_ff[COUNT_BITS/2-1:0]));
         end
         ST_MUL_HI: begin
            mul_a = MUL_A_W'($signed(cfg.sweep_step));
            mul_b = $signed(MUL_B_W'(cnt_ff[COUNT_BITS-1:COUNT_BITS/2]));
         end
         ST_DELAY: begin
            mul_a = $signed(MUL_A_W'(ms_ff));
            mul_b = $signed(MUL_B_W'(cfg.samples_per_ms));
         end
         ST_DIFF: begin
            mul_a = $signed(MUL_A_W'(fd_ff));
            mul_b = MUL_B_W'(diff);
         end
         ST_WET: begin
            mul_a = $signed(acc_ff[MUL_A_W-1:0]);
            mul_b = $signed(MUL_B_W'(cfg.depth_gain));
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Sweep delay: floor the product to Q.11 ms, add start, clamp to 24 ms
   assign sweep_shifted = acc_ff >>> SWEEP_SHIFT;
   assign sweep_ms      = sweep_shifted + $signed(ACC_W'(cfg.sweep_start_ms));

   always_comb begin
      if (use_ff) begin
         if (offset_ff < 0) begin
            ms_in = '0;
         end else if (offset_ff > $signed(OFFSET_BITS'(MAX_MS_Q11))) begin
            ms_in = MS_BITS'(MAX_MS_Q11);
         end else begin
            ms_in = offset_ff[MS_BITS-1:0];
         end
      end else begin
         if (sweep_ms < 0) begin
            ms_in = '0;
         end else if (sweep_ms > $signed(ACC_W'(MAX_MS_Q11))) begin
            ms_in = MS_BITS'(MAX_MS_Q11);
         end else begin
            ms_in = sweep_ms[MS_BITS-1:0];
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      case (state_ff)
         ST_MUL_HI: acc_in = ACC_W'(prod_ff);
         ST_SUM:    acc_in = acc_ff + (ACC_W'(prod_ff) <<< (COUNT_BITS / 2));
         ST_INTERP: acc_in = (ACC_W'(a_ff) <<< FRAC_BITS) + ACC_W'(prod_ff);
         default:   acc_in = acc_ff;
      endcase
   end

   // Remove the Q.34 scale rounding half up, then mix and saturate
   assign wet_round = prod_ff + ROUND_HALF;
   assign wet       = wet_round[PROD_W-1:FRAC_BITS+GAIN_FRAC];
   assign mix       = (WET_W + 1)'(dry_ff) + (WET_W + 1)'(wet);

   always_comb begin
      if (mix > SAMPLE_MAX) begin
         rsp_data_in = SAMPLE_MAX[SAMPLE_BITS-1:0];
      end else if (mix < SAMPLE_MIN) begin
         rsp_data_in = SAMPLE_MIN[SAMPLE_BITS-1:0];
      end else begin
         rsp_data_in = mix[SAMPLE_BITS-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      wp_in    = wp_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + LINE_ADDR_W'(1);
            if (clr_ff == LINE_ADDR_W'(LINE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (in_fire) begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_SUM;
         ST_SUM:    state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_DELAY;
         ST_DELAY:  state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_RDB;
         ST_RDB:    state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_INTERP;
         ST_INTERP: state_in = ST_WET;
         ST_WET:    state_in = ST_OUT;
         ST_OUT: begin
            // hold until the output register is free
            if (out_load) begin
               state_in = ST_IDLE;
               wp_in    = wp_ff + LINE_ADDR_W'(1);
               if (cnt_ff != '1) begin
                  cnt_in = cnt_ff + COUNT_BITS'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         wp_ff    <= wp_in;
         cnt_ff   <= cnt_in;
         if (state_ff == ST_OUT && out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         dry_ff    <= $signed(req_tdata[SAMPLE_BITS-1:0]);
         offset_ff <= $signed(req_tdata[SAMPLE_BITS+OFFSET_BITS-1:SAMPLE_BITS]);
         use_ff    <= req_tuser;
      end
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      acc_ff <= acc_in;
      if (state_ff == ST_CLAMP) begin
         ms_ff <= ms_in;
      end
      if (state_ff == ST_ADDR) begin
         fd_ff <= prod_ff[FRAC_BITS-1:0];
         ia_ff <= ia_calc;
      end
      if (state_ff == ST_RDB) begin
         a_ff <= $signed(ram_rdata);
      end
      if (state_ff == ST_OUT && out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `SFD_ASSERT_NEXT(a_accept_starts, in_fire, state_ff == ST_MUL_LO, "item not started")
   `SFD_ASSERT_SAME(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT, "stray result")
   `SFD_ASSERT_NEXT(a_wp_advance, out_step, wp_ff == $past(wp_ff) + LINE_ADDR_W'(1), "wp stuck")
   `SFD_ASSERT_NEXT(a_cnt_saturate, out_step && cnt_ff == '1, cnt_ff == '1, "counter wrapped")
   `SFD_ASSERT_SAME(a_ms_clamped, state_ff == ST_DELAY, ms_ff <= MS_BITS'(MAX_MS_Q11), "ms range")

endmodule

### rtl/sfd_line_ram.sv
// ----------------------------------------------------------------------------
// Swept flanger delay line memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfd_line_ram
   import sfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [LINE_ADDR_W-1:0] wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic [LINE_ADDR_W-1:0] rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] mem [LINE_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sfd_csr.sv
// ----------------------------------------------------------------------------
// Swept flanger delay register block
// Four configuration registers behind a zero-wait-state APB-style port.
// ----------------------------------------------------------------------------
module sfd_csr
   import sfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_fire;

   assign reg_index  = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (reg_index)
            REG_START_OFFSET: cfg_in.sweep_start_ms = csr_pwdata[MS_BITS-1:0];
            REG_SWEEP_STEP:   cfg_in.sweep_step     = csr_pwdata[STEP_BITS-1:0];
            REG_DEPTH_GAIN:   cfg_in.depth_gain     = csr_pwdata[GAIN_BITS-1:0];
            REG_SAMPLES_MS:   cfg_in.samples_per_ms = csr_pwdata[SPM_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_start_ms <= '0;
         cfg_ff.sweep_step     <= '0;
         cfg_ff.depth_gain     <= DEPTH_GAIN_RESET;
         cfg_ff.samples_per_ms <= SPM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_START_OFFSET: csr_prdata = CSR_DATA_W'(cfg_ff.sweep_start_ms);
         REG_SWEEP_STEP:   csr_prdata = CSR_DATA_W'(cfg_ff.sweep_step);
         REG_DEPTH_GAIN:   csr_prdata = CSR_DATA_W'(cfg_ff.depth_gain);
         REG_SAMPLES_MS:   csr_prdata = CSR_DATA_W'(cfg_ff.samples_per_ms);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
